[rtl/core/rlrs_pkg.sv]
`timescale 1ns / 1ps
package rlrs_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 20;
    localparam logic [4:0] LAST_ENTRY = 5'(TABLE_ENTRIES - 1);

    // Payload widths
    localparam int POS_W    = 5;
    localparam int RELAY_W  = 9;
    localparam int RES_W    = 16;
    localparam int BASE_W   = 15;
    localparam int RATIO_W  = 16;
    localparam int PROD_W   = BASE_W + RATIO_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Operation codes
    localparam logic [1:0] OP_MATCH   = 2'd0;
    localparam logic [1:0] OP_LOWER   = 2'd1;
    localparam logic [1:0] OP_HIGHER  = 2'd2;
    localparam logic [1:0] OP_REFRESH = 2'd3;

    localparam logic [BASE_W-1:0] BASE_RESET = 15'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_STEP,
        ST_MULT,
        ST_RESULT
    } rlrs_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // take the input item, clear the scan counter
        logic scan_adv;  // multiply entry at scan counter, advance counter
        logic track;     // fold registered product into the match search
        logic decide;    // apply the tie rule, write position
        logic step;      // step or hold position for ops other than match
        logic use_pos;   // multiply entry at the current position
        logic capture;   // load the output register
    } rlrs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_match;   // incoming item is a match request
        logic scan_last;  // scan counter sits on the last entry
        logic cnt_zero;   // scan counter sits on the first entry
    } rlrs_status_t;

    // Q2.14 resistance ratios, descending
    function automatic logic [RATIO_W-1:0] ratio_of(input logic [POS_W-1:0] idx);
        logic [RATIO_W-1:0] r;
        case (idx)
            5'd0:    r = 16'd32768;
            5'd1:    r = 16'd27307;
            5'd2:    r = 16'd24576;
            5'd3:    r = 16'd16384;
            5'd4:    r = 16'd13653;
            5'd5:    r = 16'd12288;
            5'd6:    r = 16'd10923;
            5'd7:    r = 16'd10240;
            5'd8:    r = 16'd9830;
            5'd9:    r = 16'd8192;
            5'd10:   r = 16'd6554;
            5'd11:   r = 16'd6144;
            5'd12:   r = 16'd5461;
            5'd13:   r = 16'd5120;
            5'd14:   r = 16'd4915;
            5'd15:   r = 16'd4096;
            5'd16:   r = 16'd3277;
            5'd17:   r = 16'd3072;
            5'd18:   r = 16'd2731;
            default: r = 16'd2048;
        endcase
        return r;
    endfunction

    // Relay word per entry: bit 8 parallel switch, bits 7..0 switches 0..7
    function automatic logic [RELAY_W-1:0] relay_of(input logic [POS_W-1:0] idx);
        logic [RELAY_W-1:0] w;
        case (idx)
            5'd0:    w = 9'h044;
            5'd1:    w = 9'h000;
            5'd2:    w = 9'h022;
            5'd3:    w = 9'h055;
            5'd4:    w = 9'h100;
            5'd5:    w = 9'h122;
            5'd6:    w = 9'h011;
            5'd7:    w = 9'h088;
            5'd8:    w = 9'h0AA;
            5'd9:    w = 9'h033;
            5'd10:   w = 9'h0CC;
            5'd11:   w = 9'h0EE;
            5'd12:   w = 9'h0DD;
            5'd13:   w = 9'h188;
            5'd14:   w = 9'h1AA;
            5'd15:   w = 9'h0FF;
            5'd16:   w = 9'h1CC;
            5'd17:   w = 9'h1EE;
            5'd18:   w = 9'h1DD;
            default: w = 9'h1FF;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/rlrs_datapath.sv]
`timescale 1ns / 1ps
module rlrs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [rlrs_pkg::BASE_W-1:0]         cfg_data,
    input  logic [rlrs_pkg::IN_TDATA_W-1:0]     in_data,
    input  rlrs_pkg::rlrs_cmd_t                 cmd,
    output rlrs_pkg::rlrs_status_t              status,
    output logic [rlrs_pkg::OUT_TDATA_W-1:0]    out_data
);
    import rlrs_pkg::*;

    logic [BASE_W-1:0]  base_reg;
    logic [1:0]         op_reg;
    logic [RES_W-1:0]   target_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   cnt_reg;
    logic [POS_W-1:0]   addr;
    logic [PROD_W-1:0]  product;
    logic [RES_W-1:0]   prod_reg;
    logic [POS_W-1:0]   pidx_reg;
    logic [POS_W-1:0]   sel_reg;
    logic [RES_W-1:0]   rsel_reg;
    logic [RES_W-1:0]   rnext_reg;
    logic [RES_W:0]     pair_sum;
    logic [POS_W-1:0]   out_pos_reg;
    logic [RELAY_W-1:0] out_relay_reg;
    logic [RES_W-1:0]   out_res_reg;

    // Unit resistance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_data;
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data[1:0];
            target_reg <= in_data[17:2];
        end
    end

    // Scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.scan_adv)
        begin
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // Shared multiplier, registered product truncated to Q8.8
    assign addr    = cmd.use_pos ? pos_reg : cnt_reg;
    assign product = PROD_W'(base_reg) * PROD_W'(ratio_of(addr));

    always_ff @(posedge clk)
    begin
        if (cmd.scan_adv || cmd.use_pos)
        begin
            prod_reg <= product[RES_W+13:14];
            pidx_reg <= addr;
        end
    end

    // Track the last entry at or above the target and its lower neighbor
    always_ff @(posedge clk)
    begin
        if (cmd.track)
        begin
            if (pidx_reg == '0)
            begin
                sel_reg  <= '0;
                rsel_reg <= prod_reg;
            end
            else
            begin
                if (prod_reg >= target_reg)
                begin
                    sel_reg  <= pidx_reg;
                    rsel_reg <= prod_reg;
                end
                if (pidx_reg == sel_reg + 5'd1)
                begin
                    rnext_reg <= prod_reg;
                end
            end
        end
    end

    // Nearer lower neighbor wins only when strictly nearer
    assign pair_sum = {1'b0, rsel_reg} + {1'b0, rnext_reg};

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.decide)
        begin
            if (sel_reg != LAST_ENTRY && pair_sum > {target_reg, 1'b0})
                pos_next = sel_reg + 5'd1;
            else
                pos_next = sel_reg;
        end
        else if (cmd.step)
        begin
            case (op_reg)
                OP_LOWER:
                begin
                    if (pos_reg < LAST_ENTRY)
                        pos_next = pos_reg + 5'd1;
                end
                OP_HIGHER:
                begin
                    if (pos_reg != '0)
                        pos_next = pos_reg - 5'd1;
                end
                OP_REFRESH: pos_next = pos_reg;
                default:    pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_pos_reg   <= pos_reg;
            out_relay_reg <= relay_of(pos_reg);
            out_res_reg   <= prod_reg;
        end
    end

    assign out_data = {1'b0, out_res_reg, ~out_relay_reg, out_relay_reg, out_pos_reg};

    assign status.in_match  = (in_data[1:0] == OP_MATCH);
    assign status.scan_last = (cnt_reg == LAST_ENTRY);
    assign status.cnt_zero  = (cnt_reg == '0);

    // Position never leaves the table
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_ENTRY)
        else $error("position beyond last entry");

    // Decision lands on the tracked entry or its lower neighbor
    a_decide_pick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> (pos_reg == $past(sel_reg) || pos_reg == $past(sel_reg) + 5'd1))
        else $error("decision outside tracked pair");

    // A step moves position by at most one entry
    a_step_size: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (pos_reg == $past(pos_reg) || pos_reg == $past(pos_reg) + 5'd1
                      || pos_reg == $past(pos_reg) - 5'd1))
        else $error("step moved more than one entry");

endmodule

[rtl/core/rlrs_ctrl.sv]
`timescale 1ns / 1ps
module rlrs_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  rlrs_pkg::rlrs_status_t  status,
    output rlrs_pkg::rlrs_cmd_t     cmd
);
    import rlrs_pkg::*;

    rlrs_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.in_match ? ST_SCAN : ST_STEP;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_MULT;
            ST_STEP:   state_next = ST_MULT;
            ST_MULT:   state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_adv = 1'b1;
                cmd.track    = !status.cnt_zero;
            end
            ST_DRAIN:  cmd.track   = 1'b1;
            ST_DECIDE: cmd.decide  = 1'b1;
            ST_STEP:   cmd.step    = 1'b1;
            ST_MULT:   cmd.use_pos = 1'b1;
            ST_RESULT: cmd.capture = slot_free;
            default:   cmd = '0;
        endcase
    end

    // Output valid: set on capture, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Never overwrite a result still waiting for transfer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    // Scan ends after the last entry is multiplied
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.scan_last) |=> state_reg == ST_DRAIN)
        else $error("scan did not stop at last entry");

    // Capture is followed by a valid result
    a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid_reg)
        else $error("captured result not presented");

endmodule

[rtl/core/relay_load_resistance_selector_unit.sv]
`timescale 1ns / 1ps
// Relay load resistance selector. Each input item matches a target resistance,
// steps one table entry lower or higher, or refreshes, and returns the selected
// entry of a 20-entry table of relay combinations together with its relay word,
// active-low pin levels and resistance (unit resistance times a fixed ratio,
// Q8.8 ohms). Items are handled one at a time. For a match the 20 entries pass
// one per cycle through a single 15x16 multiplier, followed by drain, tie
// decision, a product for the chosen entry and the output load. Step and refresh
// go through the step, product and output load states. The output
// register lets the next item enter while a result waits to be taken. The unit
// resistance register is written through cfg_valid/cfg_data and resets to 1 ohm.
module relay_load_resistance_selector_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,       // base_resistance
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op[1:0], target_resistance[17:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // table_position[4:0], relay_bits[13:5],
                                        // pin_levels[22:14], selected_resistance[38:23]
);
    import rlrs_pkg::*;

    rlrs_cmd_t    cmd;
    rlrs_status_t status;

    assign cfg_ready = 1'b1;

    rlrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rlrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import rlrs_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int SETTLE_CYCLES   = 30;
    localparam int LONG_HOLD       = 400;

    // One selection as the block reports it
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [RELAY_W-1:0] relays;
        logic [RELAY_W-1:0] pins;
        logic [RES_W-1:0]   ohms;
    } load_sel_t;

    // One directed request; sel is only used where known is set
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] target;
        logic        known;
        load_sel_t   sel;
    } probe_row_t;

    // Q2.14 ratios and relay words of the switched load, highest resistance first
    localparam logic [15:0] RATIO_Q214 [TABLE_ENTRIES] = '{
        16'd32768, 16'd27307, 16'd24576, 16'd16384, 16'd13653,
        16'd12288, 16'd10923, 16'd10240, 16'd9830,  16'd8192,
        16'd6554,  16'd6144,  16'd5461,  16'd5120,  16'd4915,
        16'd4096,  16'd3277,  16'd3072,  16'd2731,  16'd2048
    };
    localparam logic [RELAY_W-1:0] RELAY_WORD [TABLE_ENTRIES] = '{
        9'h044, 9'h000, 9'h022, 9'h055, 9'h100, 9'h122, 9'h011, 9'h088, 9'h0AA, 9'h033,
        9'h0CC, 9'h0EE, 9'h0DD, 9'h188, 9'h1AA, 9'h0FF, 9'h1CC, 9'h1EE, 9'h1DD, 9'h1FF
    };

    // Selections readable at a glance with the 1 ohm unit resistance
    localparam load_sel_t SEL_TOP    = '{5'd0, 9'h044, 9'h1BB, 16'd512};
    localparam load_sel_t SEL_BOTTOM = '{5'd19, 9'h1FF, 9'h000, 16'd32};
    localparam load_sel_t SEL_NONE   = '0;

    localparam probe_row_t PROBES [23] = '{
        '{OP_REFRESH, 16'd0,     1'b1, SEL_TOP},
        '{OP_HIGHER,  16'hFFFF,  1'b1, SEL_TOP},      // saturate at the top
        '{OP_LOWER,   16'd0,     1'b0, SEL_NONE},
        '{OP_LOWER,   16'd1234,  1'b0, SEL_NONE},
        '{OP_HIGHER,  16'd0,     1'b0, SEL_NONE},
        '{OP_MATCH,   16'hFFFF,  1'b1, SEL_TOP},      // above every entry
        '{OP_MATCH,   16'd0,     1'b1, SEL_BOTTOM},   // below every entry
        '{OP_LOWER,   16'd0,     1'b1, SEL_BOTTOM},   // saturate at the bottom
        '{OP_REFRESH, 16'hFFFF,  1'b1, SEL_BOTTOM},
        '{OP_MATCH,   16'd469,   1'b0, SEL_NONE},     // exact tie between 512 and 426
        '{OP_MATCH,   16'd468,   1'b0, SEL_NONE},
        '{OP_MATCH,   16'd470,   1'b0, SEL_NONE},
        '{OP_MATCH,   16'd256,   1'b0, SEL_NONE},     // exact hit
        '{OP_MATCH,   16'd32,    1'b1, SEL_BOTTOM},   // exact hit on the last entry
        '{OP_MATCH,   16'd33,    1'b0, SEL_NONE},
        '{OP_MATCH,   16'd31,    1'b1, SEL_BOTTOM},
        '{OP_MATCH,   16'd512,   1'b0, SEL_NONE},
        '{OP_MATCH,   16'd513,   1'b1, SEL_TOP},
        '{OP_MATCH,   16'hAAAA,  1'b1, SEL_TOP},
        '{OP_MATCH,   16'h5555,  1'b1, SEL_TOP},
        '{OP_MATCH,   16'd150,   1'b0, SEL_NONE},
        '{OP_HIGHER,  16'd0,     1'b0, SEL_NONE},
        '{OP_REFRESH, 16'd0,     1'b0, SEL_NONE}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BASE_W-1:0]     cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow of the unit state
    logic [BASE_W-1:0] base_q88;
    logic [POS_W-1:0]  sel_position;
    load_sel_t         sel_queue [$];

    bit idle_on;
    int sink_hold_cycles;
    int mismatches;
    int items_sent;
    int results_seen;
    int cycles;

    relay_load_resistance_selector_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Resistance of one table entry at the current unit resistance, truncated
    function automatic logic [RES_W-1:0] entry_ohms(input int idx);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(base_q88) * PROD_W'(RATIO_Q214[idx]);
        return RES_W'(prod >> 14);
    endfunction

    // Advance the selected position for one request and return the selection
    function automatic load_sel_t predict_selection(input logic [1:0] op,
                                                    input logic [15:0] target);
        load_sel_t r;
        int i;
        int pick;
        int gap_above;
        int gap_below;
        case (op)
            OP_MATCH:
            begin
                pick = 0;
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (entry_ohms(i) >= target)
                        pick = i;
                // Take the lower neighbor only when strictly nearer
                if (pick < TABLE_ENTRIES - 1)
                begin
                    gap_above = int'(entry_ohms(pick)) - int'(target);
                    gap_below = int'(target) - int'(entry_ohms(pick + 1));
                    if (gap_above > gap_below)
                        pick++;
                end
                sel_position = POS_W'(pick);
            end
            OP_LOWER:
            begin
                if (sel_position < LAST_ENTRY)
                    sel_position = sel_position + 1'b1;
            end
            OP_HIGHER:
            begin
                if (sel_position > 0)
                    sel_position = sel_position - 1'b1;
            end
            default: ;
        endcase
        r.position = sel_position;
        r.relays   = RELAY_WORD[sel_position];
        r.pins     = ~RELAY_WORD[sel_position];
        r.ohms     = entry_ohms(sel_position);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 200)
            $display("MISMATCH t=%0t result %0d %s: got %0d, want %0d",
                     $time, results_seen, what, got, want);
    endtask

    // Offer one request, with an optional gap first, and log its selection
    task automatic send_item(input logic [1:0] op, input logic [15:0] target,
                             input logic known, input load_sel_t fixed);
        load_sel_t want;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'b0, target, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = predict_selection(op, target);
        if (known)
            want = fixed;
        sel_queue.push_back(want);
        items_sent++;
    endtask

    // Drop the request line and wait out every pending selection
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sel_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        base_q88 = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly matches aimed at entries, ties and the ends of the table
    task automatic pick_random_item(output logic [1:0] op, output logic [15:0] target);
        int kind;
        int idx;
        int val;
        kind   = $urandom_range(0, 11);
        idx    = $urandom_range(0, TABLE_ENTRIES - 2);
        op     = OP_MATCH;
        target = 16'($urandom);
        val    = int'(target);
        case (kind)
            0, 1:  op = OP_LOWER;
            2, 3:  op = OP_HIGHER;
            4:     op = OP_REFRESH;
            5:     op = 2'($urandom);
            6, 7:  val = int'(entry_ohms(idx)) + $urandom_range(0, 4) - 2;
            8, 9:  val = (int'(entry_ohms(idx)) + int'(entry_ohms(idx + 1))) / 2
                         + $urandom_range(0, 2) - 1;
            10:
            begin
                case ($urandom_range(0, 3))
                    0:       val = 0;
                    1:       val = 65535;
                    2:       val = int'(entry_ohms(TABLE_ENTRIES - 1)) + $urandom_range(0, 2) - 1;
                    default: val = int'(entry_ohms(0)) + $urandom_range(0, 2) - 1;
                endcase
            end
            default: ;
        endcase
        if (val < 0)
            val = 0;
        if (val > 65535)
            val = 65535;
        target = 16'(val);
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                sink_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (idle_on && rst_n && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Check each result transfer against the oldest pending selection
    always @(posedge clk)
    begin
        load_sel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (sel_queue.size() == 0)
                report_mismatch("unexpected result, position", int'(m_axis_tdata[4:0]), -1);
            else
            begin
                want = sel_queue.pop_front();
                if (m_axis_tdata[4:0] !== want.position)
                    report_mismatch("table_position", int'(m_axis_tdata[4:0]),
                                    int'(want.position));
                if (m_axis_tdata[13:5] !== want.relays)
                    report_mismatch("relay_bits", int'(m_axis_tdata[13:5]), int'(want.relays));
                if (m_axis_tdata[22:14] !== want.pins)
                    report_mismatch("pin_levels", int'(m_axis_tdata[22:14]), int'(want.pins));
                if (m_axis_tdata[38:23] !== want.ohms)
                    report_mismatch("selected_resistance", int'(m_axis_tdata[38:23]),
                                    int'(want.ohms));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [1:0]  op;
        logic [15:0] target;
        int ph;
        int n;
        int k;
        logic [BASE_W-1:0] next_base;

        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        idle_on          = 1'b1;
        sink_hold_cycles = 0;
        mismatches       = 0;
        items_sent       = 0;
        results_seen     = 0;
        cycles           = 0;
        base_q88         = BASE_RESET;
        sel_position     = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at the reset unit resistance
        for (k = 0; k < 23; k++)
            send_item(PROBES[k].op, PROBES[k].target, PROBES[k].known, PROBES[k].sel);
        settle();

        // Random requests over a series of unit resistances
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       next_base = 15'd32767;
                1:       next_base = 15'd0;
                2:       next_base = 15'd1;
                3:       next_base = 15'd3;
                4:       next_base = BASE_RESET;
                5:       next_base = 15'($urandom_range(4, 40));
                10:      next_base = 15'd16384;
                default: next_base = 15'($urandom_range(0, 32767));
            endcase
            write_base(next_base);
            idle_on = (ph != PHASES - 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 6 && n == 40)
                    sink_hold_cycles = LONG_HOLD;
                if (ph == 7 && n == 60)
                begin
                    @(negedge clk);
                    s_axis_tvalid = 1'b0;
                    while (sel_queue.size() != 0)
                        @(posedge clk);
                end
                pick_random_item(op, target);
                send_item(op, target, 1'b0, SEL_NONE);
            end
            settle();
        end

        $display("Sent %0d requests (directed, then %0d unit resistance settings), %0d results",
                 items_sent, PHASES, results_seen);
        $display("Covered ties, table ends, step saturation, output hold and input pause");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rlrs_pkg.sv
rtl/core/rlrs_datapath.sv
rtl/core/rlrs_ctrl.sv
rtl/core/relay_load_resistance_selector_unit.sv
bench/tb_top.sv
